[rtl/wfr_pkg.sv]
// Shared types, register indexes, event codes and the CRC-8 byte update of the frame receiver.
package wfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned EventW  = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OutW    = 40;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FRAME_END   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESC_END     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ESC_ESCAPE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CRC_SEED    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN     = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] RST_FRAME_END  = 8'd192;
  localparam logic [ByteW-1:0] RST_ESCAPE     = 8'd219;
  localparam logic [ByteW-1:0] RST_ESC_END    = 8'd220;
  localparam logic [ByteW-1:0] RST_ESC_ESCAPE = 8'd221;
  localparam logic [ByteW-1:0] RST_CRC_SEED   = 8'd222;
  localparam logic [ByteW-1:0] RST_MAX_LEN    = 8'd128;

  localparam logic [ByteW-1:0] CrcXorMask = 8'h18;
  localparam logic [ByteW-1:0] AddrFlag   = 8'h80;

  typedef enum logic [EventW-1:0] {
    EV_DATA     = 2'd0,
    EV_FRAME_OK = 2'd1,
    EV_CRC_BAD  = 2'd2,
    EV_TOO_LONG = 2'd3
  } event_e;

  // One result beat, packed high field first.
  typedef struct packed {
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] frame_command;
    logic             address_present;
    logic [AddrW-1:0] frame_address;
    logic [ByteW-1:0] data_index;
    logic [ByteW-1:0] data_byte;
  } result_t;

  // Dallas/Maxim CRC-8, reflected, one byte LSB first.
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] data,
                                                 input logic [ByteW-1:0] crc_in);
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] b;
    c = crc_in;
    b = data;
    for (int i = 0; i < ByteW; i++) begin
      if (b[0] ^ c[0]) begin
        c = ((c ^ CrcXorMask) >> 1) | AddrFlag;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

[rtl/wake_frame_receiver.sv]
// Deframer for a byte-stuffed serial link with CRC-8 check; top level.
//
// The block takes raw line bytes on the slave stream and gives one beat on the master
// stream for every destuffed data byte and for every frame outcome (frame ok, CRC
// mismatch, length too long). A raw frame end code restarts a frame at any time; an
// escape code pairs with the next byte; the escaped codes map back, other bytes pass as is.
// The destuffed frame is an optional address byte (bit 7 set), a command, a length, the
// data and a CRC-8 byte; the CRC is seeded with crc_seed and run over the frame end code,
// the 7-bit address, command, length and data. Each byte sits in an input register, then one
// pass of destuffing, phase decode and byte-wide CRC update writes the output register, so a
// byte can be accepted every cycle while the output is drained.
// Throughput is one byte per clock while the output is drained.
// Back-pressure on the master side stalls the input register and then s_axis_tready.
// Configuration writes (index 0..5: frame end, escape, escaped end, escaped escape,
// CRC seed, max data length) are always ready and must only be issued while idle;
// other indexes are ignored.
module wake_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // raw line byte: [7:0] rx_byte
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [wfr_pkg::ByteW-1:0]   s_axis_tdata,
  // [7:0] data_byte, [15:8] data_index, [22:16] frame_address, [23] address_present,
  // [31:24] frame_command, [39:32] frame_length
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [wfr_pkg::OutW-1:0]    m_axis_tdata,
  // [1:0] event_res
  output logic [wfr_pkg::EventW-1:0]  m_axis_tuser,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wfr_pkg::ByteW-1:0]   cfg_data_i
);
  import wfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_e;

  // configuration
  logic [ByteW-1:0] fend_q, fesc_q, tfend_q, tfesc_q, seed_q, max_len_q;

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;

  // frame state
  phase_e           phase_q, phase_d;
  logic             esc_q, esc_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             has_addr_q, has_addr_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] seen_q, seen_d;
  logic [ByteW-1:0] crc_q, crc_d;

  // output register
  logic             out_vld_q;
  event_e           evt_q, evt_d;
  result_t          res_q, res_d;
  logic             emit_d;

  logic             advance;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] crc_upd;
  logic [ByteW-1:0] crc_in;

  // Move the held byte through the decoder when the output slot is free or draining.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = evt_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fend_q    <= RST_FRAME_END;
      fesc_q    <= RST_ESCAPE;
      tfend_q   <= RST_ESC_END;
      tfesc_q   <= RST_ESC_ESCAPE;
      seed_q    <= RST_CRC_SEED;
      max_len_q <= RST_MAX_LEN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_END:  fend_q    <= cfg_data_i;
        CFG_ESCAPE:     fesc_q    <= cfg_data_i;
        CFG_ESC_END:    tfend_q   <= cfg_data_i;
        CFG_ESC_ESCAPE: tfesc_q   <= cfg_data_i;
        CFG_CRC_SEED:   seed_q    <= cfg_data_i;
        CFG_MAX_LEN:    max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Destuff the escaped byte: map the second byte of a pair back.
  always_comb begin
    b = in_byte_q;
    if (esc_q) begin
      if (in_byte_q == tfend_q) begin
        b = fend_q;
      end else if (in_byte_q == tfesc_q) begin
        b = fesc_q;
      end
    end
  end

  // One shared byte-wide CRC update; the frame end case feeds the seed instead.
  always_comb begin
    crc_in = crc_q;
    if (in_byte_q == fend_q) begin
      crc_in = seed_q;
    end
  end
  assign crc_upd = crc8_byte((in_byte_q == fend_q) ? fend_q :
                             ((phase_q == PH_FIRST) && b[ByteW-1]) ?
                             {1'b0, b[AddrW-1:0]} : b, crc_in);

  // Frame decoder for one byte.
  always_comb begin
    phase_d    = phase_q;
    esc_d      = esc_q;
    addr_d     = addr_q;
    has_addr_d = has_addr_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    seen_d     = seen_q;
    crc_d      = crc_q;
    emit_d     = 1'b0;
    evt_d      = EV_DATA;
    res_d.data_byte  = '0;
    res_d.data_index = '0;

    if (in_byte_q == fend_q) begin
      // restart the frame in any phase
      phase_d    = PH_FIRST;
      esc_d      = 1'b0;
      addr_d     = '0;
      has_addr_d = 1'b0;
      crc_d      = crc_upd;
    end else if (!esc_q && (in_byte_q == fesc_q)) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      case (phase_q)
        PH_FIRST: begin
          crc_d = crc_upd;
          if (b[ByteW-1]) begin
            addr_d     = b[AddrW-1:0];
            has_addr_d = 1'b1;
            phase_d    = PH_CMD;
          end else begin
            addr_d     = '0;
            has_addr_d = 1'b0;
            cmd_d      = b;
            phase_d    = PH_LEN;
          end
        end
        PH_CMD: begin
          cmd_d   = b;
          crc_d   = crc_upd;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d  = b;
          seen_d = '0;
          crc_d  = crc_upd;
          if (b > max_len_q) begin
            phase_d = PH_IDLE;
            emit_d  = 1'b1;
            evt_d   = EV_TOO_LONG;
          end else if (b != '0) begin
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_CRC;
          end
        end
        PH_DATA: begin
          crc_d            = crc_upd;
          seen_d           = seen_q + 8'd1;
          emit_d           = 1'b1;
          evt_d            = EV_DATA;
          res_d.data_byte  = b;
          res_d.data_index = seen_q;
          if (seen_d == len_q) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_d = PH_IDLE;
          emit_d  = 1'b1;
          evt_d   = (b == crc_q) ? EV_FRAME_OK : EV_CRC_BAD;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    res_d.frame_address   = addr_d;
    res_d.address_present = has_addr_d;
    res_d.frame_command   = cmd_d;
    res_d.frame_length    = len_d;
  end

  // Input register: hold the byte until the decoder takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Frame state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      esc_q      <= 1'b0;
      addr_q     <= '0;
      has_addr_q <= 1'b0;
      cmd_q      <= '0;
      len_q      <= '0;
      seen_q     <= '0;
      crc_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (advance) begin
        phase_q    <= phase_d;
        esc_q      <= esc_d;
        addr_q     <= addr_d;
        has_addr_q <= has_addr_d;
        cmd_q      <= cmd_d;
        len_q      <= len_d;
        seen_q     <= seen_d;
        crc_q      <= crc_d;
      end
      if (advance) begin
        out_vld_q <= emit_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit_d) begin
      evt_q <= evt_d;
      res_q <= res_d;
    end
  end

endmodule

[verif/wake_frame_receiver_tb.sv]
// Self-checking testbench for the byte-stuffed frame receiver with CRC-8 check.
`timescale 1ns / 1ps

module wake_frame_receiver_tb;
  import wfr_pkg::*;

  typedef logic [ByteW-1:0] byte_t;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseBeats    = 100;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned QuietCycles   = 6;
  localparam int unsigned TimeoutNs     = 10_000_000;
  localparam byte_t       CrcPoly       = 8'h8C;  // reflected Dallas/Maxim polynomial

  typedef enum logic [2:0] {
    RX_IDLE, RX_FIRST, RX_CMD, RX_LEN, RX_DATA, RX_CRC
  } rx_state_e;

  // One expected output beat: event code plus the packed data fields.
  typedef struct packed {
    event_e  ev;
    result_t res;
  } frame_event_t;

  // Tracks deframer state, predicts output beats and checks them in order.
  class frame_event_board;
    byte_t          fe, esc, esc_end, esc_esc, seed, max_len;
    rx_state_e      rx_state;
    bit             esc_pend;
    logic [AddrW-1:0] addr;
    bit             addr_ok;
    byte_t          cmd, len, seen, crc;
    frame_event_t   pending[$];
    int unsigned    mismatches;

    function new();
      fe = RST_FRAME_END;
      esc = RST_ESCAPE;
      esc_end = RST_ESC_END;
      esc_esc = RST_ESC_ESCAPE;
      seed = RST_CRC_SEED;
      max_len = RST_MAX_LEN;
      rx_state = RX_IDLE;
      esc_pend = 1'b0;
      addr = '0;
      addr_ok = 1'b0;
      cmd = '0;
      len = '0;
      seen = '0;
      crc = '0;
      mismatches = 0;
    endfunction

    static function byte_t crc_next(byte_t d, byte_t c);
      for (int i = 0; i < ByteW; i++) begin
        if ((d[0] ^ c[0]) != 1'b0) begin
          c = (c >> 1) ^ CrcPoly;
        end else begin
          c = c >> 1;
        end
        d = d >> 1;
      end
      return c;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, byte_t v);
      case (idx)
        CFG_FRAME_END:  fe = v;
        CFG_ESCAPE:     esc = v;
        CFG_ESC_END:    esc_end = v;
        CFG_ESC_ESCAPE: esc_esc = v;
        CFG_CRC_SEED:   seed = v;
        CFG_MAX_LEN:    max_len = v;
        default: ;
      endcase
    endfunction

    function void queue_event(event_e ev, byte_t d, byte_t idx);
      frame_event_t e;
      e.ev = ev;
      e.res.data_byte = d;
      e.res.data_index = idx;
      e.res.frame_address = addr;
      e.res.address_present = addr_ok;
      e.res.frame_command = cmd;
      e.res.frame_length = len;
      pending.push_back(e);
    endfunction

    // Advance the deframer by one accepted line byte.
    function void note_rx_byte(byte_t raw);
      byte_t b;
      b = raw;
      // A raw frame end always wins, even over a pending escape.
      if (b == fe) begin
        rx_state = RX_FIRST;
        esc_pend = 1'b0;
        addr = '0;
        addr_ok = 1'b0;
        crc = crc_next(fe, seed);
        return;
      end
      if (!esc_pend && b == esc) begin
        esc_pend = 1'b1;
        return;
      end
      if (esc_pend) begin
        esc_pend = 1'b0;
        if (b == esc_end) begin
          b = fe;
        end else if (b == esc_esc) begin
          b = esc;
        end
      end
      case (rx_state)
        RX_FIRST: begin
          if (b[7]) begin
            addr = b[AddrW-1:0];
            addr_ok = 1'b1;
            crc = crc_next({1'b0, b[AddrW-1:0]}, crc);
            rx_state = RX_CMD;
          end else begin
            addr = '0;
            addr_ok = 1'b0;
            cmd = b;
            crc = crc_next(b, crc);
            rx_state = RX_LEN;
          end
        end
        RX_CMD: begin
          cmd = b;
          crc = crc_next(b, crc);
          rx_state = RX_LEN;
        end
        RX_LEN: begin
          len = b;
          seen = '0;
          crc = crc_next(b, crc);
          if (b > max_len) begin
            rx_state = RX_IDLE;
            queue_event(EV_TOO_LONG, '0, '0);
          end else begin
            rx_state = (b != '0) ? RX_DATA : RX_CRC;
          end
        end
        RX_DATA: begin
          queue_event(EV_DATA, b, seen);
          crc = crc_next(b, crc);
          seen = seen + 8'd1;
          if (seen == len) begin
            rx_state = RX_CRC;
          end
        end
        RX_CRC: begin
          rx_state = RX_IDLE;
          queue_event((b == crc) ? EV_FRAME_OK : EV_CRC_BAD, '0, '0);
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [ByteW-1:0] exp_v, logic [ByteW-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_event(result_t got, logic [EventW-1:0] got_ev);
      frame_event_t e;
      if (pending.size() == 0) begin
        $error("output beat with nothing expected: event %0d, tdata 0x%0h", got_ev, got);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      check_field("event_res", {6'd0, e.ev}, {6'd0, got_ev});
      check_field("data_byte", e.res.data_byte, got.data_byte);
      check_field("data_index", e.res.data_index, got.data_index);
      check_field("frame_address", {1'b0, e.res.frame_address}, {1'b0, got.frame_address});
      check_field("address_present", {7'd0, e.res.address_present},
                  {7'd0, got.address_present});
      check_field("frame_command", e.res.frame_command, got.frame_command);
      check_field("frame_length", e.res.frame_length, got.frame_length);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata = '0;    // [7:0] rx_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutW-1:0]      m_axis_tdata;         // data_byte, data_index, address, present, cmd, len
  logic [EventW-1:0]    m_axis_tuser;         // [1:0] event_res
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = CFG_FRAME_END;
  logic [ByteW-1:0]     cfg_data_i = '0;

  frame_event_board sb;

  // Generator-side copy of the settings, used to build frames.
  byte_t cfg_fe = RST_FRAME_END;
  byte_t cfg_esc = RST_ESCAPE;
  byte_t cfg_ee = RST_ESC_END;
  byte_t cfg_eesc = RST_ESC_ESCAPE;
  byte_t cfg_seed = RST_CRC_SEED;
  byte_t cfg_max_len = RST_MAX_LEN;

  int unsigned burst_left = 0;
  int unsigned frame_beats = 0;
  bit          hold_off_req = 1'b0;
  byte_t       data_plan[$];

  wake_frame_receiver dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sample all three channels on the edge; results are checked before the
  // byte of the same edge is noted, since no result comes out in the cycle its byte is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_event(result_t'(m_axis_tdata), m_axis_tuser);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_rx_byte(s_axis_tdata);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(cfg_index_i, cfg_data_i);
      end
    end
  end

  // Output back-pressure: a random stall pattern that switches among four modes,
  // plus one long hold-off on request so the block fills up.
  initial begin : rx_stall
    int unsigned cyc;
    int unsigned mode;
    bit          rdy;
    cyc = 0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        if (cyc % 48 == 0) begin
          mode = $urandom_range(0, 3);
        end
        cyc++;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (cyc % 4 == 0);
          default: rdy = ($urandom_range(0, 3) != 0);
        endcase
        m_axis_tready <= rdy;
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("** wake_frame_receiver: FAILED **");
    $finish;
  end

  // Offer one line byte; bursts of random length with random gaps between them.
  task automatic send_raw(input byte_t b, input bit counted = 1'b1);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counted) begin
      frame_beats++;
    end
  endtask

  // Stuff one logical byte with the current codes.
  task automatic send_stuffed(input byte_t v);
    if (v == cfg_fe) begin
      send_raw(cfg_esc);
      send_raw(cfg_ee);
    end else if (v == cfg_esc) begin
      send_raw(cfg_esc);
      send_raw(cfg_eesc);
    end else begin
      send_raw(v);
    end
  endtask

  // Data bytes lean toward the codes so that stuffing is exercised often.
  function automatic byte_t pick_data();
    case ($urandom_range(0, 11))
      0:       return cfg_fe;
      1:       return cfg_esc;
      2:       return cfg_ee;
      3:       return cfg_eesc;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_t fresh_code(byte_t a, byte_t b, byte_t c);
    byte_t v;
    do v = byte_t'($urandom_range(0, 255)); while (v == a || v == b || v == c);
    return v;
  endfunction

  // Stuffed frame with a good or corrupted CRC; data comes from data_plan first, then at random.
  task automatic send_frame(input bit with_addr, input logic [AddrW-1:0] addr,
                            input byte_t cmd, input byte_t len, input bit good_crc);
    byte_t crc;
    byte_t d;
    crc = frame_event_board::crc_next(cfg_fe, cfg_seed);
    send_raw(cfg_fe);
    if (with_addr) begin
      send_stuffed({1'b1, addr});
      crc = frame_event_board::crc_next({1'b0, addr}, crc);
    end
    send_stuffed(cmd);
    crc = frame_event_board::crc_next(cmd, crc);
    send_stuffed(len);
    crc = frame_event_board::crc_next(len, crc);
    // A too-long length ends the frame right here.
    if (len <= cfg_max_len) begin
      for (int i = 0; i < int'(len); i++) begin
        d = (data_plan.size() != 0) ? data_plan.pop_front() : pick_data();
        send_stuffed(d);
        crc = frame_event_board::crc_next(d, crc);
      end
      send_stuffed(good_crc ? crc : crc ^ byte_t'($urandom_range(1, 255)));
    end
  endtask

  // Write all six registers back to back, then update the generator copy.
  task automatic write_config(input byte_t fe, input byte_t esc, input byte_t ee,
                              input byte_t eesc, input byte_t seed, input byte_t max_len);
    logic [CfgIdxW-1:0] idx_list [6];
    byte_t              vals [6];
    idx_list = '{CFG_FRAME_END, CFG_ESCAPE, CFG_ESC_END, CFG_ESC_ESCAPE,
                 CFG_CRC_SEED, CFG_MAX_LEN};
    vals = '{fe, esc, ee, eesc, seed, max_len};
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cfg_fe = fe;
    cfg_esc = esc;
    cfg_ee = ee;
    cfg_eesc = eesc;
    cfg_seed = seed;
    cfg_max_len = max_len;
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline settle.
  // Step one edge first so the byte of the last edge has been noted.
  task automatic wait_for_quiet();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  initial begin
    byte_t       crc_tmp;
    byte_t       fe, esc, ee, eesc, seed, max_len;
    byte_t       cmd, len;
    bit          with_addr;
    int unsigned pick;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset settings.
    // Bytes while idle are ignored.
    send_raw(8'h00);
    send_raw(8'hFF);
    // Largest address and command, data holding both codes, good CRC.
    data_plan.push_back(cfg_fe);
    data_plan.push_back(cfg_esc);
    send_frame(1'b1, 7'h7F, 8'hFF, 8'd2, 1'b1);
    // No address, zero command, zero length, bad CRC.
    send_frame(1'b0, '0, 8'h00, 8'd0, 1'b0);
    // Length 255 is over the limit.
    send_frame(1'b0, '0, 8'h7F, 8'hFF, 1'b1);
    // Frame end mid-frame with an escape pending restarts cleanly; then an
    // escape pair with an ordinary second byte carries the command unchanged.
    send_raw(cfg_fe);
    send_raw(8'h81);
    send_raw(cfg_esc);
    send_raw(cfg_fe);
    send_raw(cfg_esc);
    send_raw(8'h12);
    send_raw(8'h00);
    crc_tmp = frame_event_board::crc_next(cfg_fe, cfg_seed);
    crc_tmp = frame_event_board::crc_next(8'h12, crc_tmp);
    crc_tmp = frame_event_board::crc_next(8'h00, crc_tmp);
    send_stuffed(crc_tmp);
    wait_for_quiet();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin  // low extremes, no data allowed
          fe = 8'h00; esc = 8'hFF; ee = 8'h01; eesc = 8'hFE; seed = 8'h00; max_len = 8'h00;
        end
        1: begin  // high extremes, any length allowed
          fe = 8'hFF; esc = 8'h00; ee = 8'hFE; eesc = 8'h01; seed = 8'hFF; max_len = 8'hFF;
        end
        2: begin  // colliding codes: frame end shadows escape
          fe = byte_t'($urandom_range(0, 255));
          esc = fe;
          ee = fresh_code(fe, fe, fe);
          eesc = ee;
          seed = byte_t'($urandom_range(0, 255));
          max_len = byte_t'($urandom_range(0, 20));
        end
        NumPhases - 1: begin  // back to reset values
          fe = RST_FRAME_END; esc = RST_ESCAPE; ee = RST_ESC_END; eesc = RST_ESC_ESCAPE;
          seed = RST_CRC_SEED; max_len = RST_MAX_LEN;
        end
        default: begin
          fe = byte_t'($urandom_range(0, 255));
          esc = fresh_code(fe, fe, fe);
          ee = fresh_code(fe, esc, esc);
          eesc = fresh_code(fe, esc, ee);
          seed = byte_t'($urandom_range(0, 255));
          max_len = byte_t'($urandom_range(1, 24));
        end
      endcase
      write_config(fe, esc, ee, eesc, seed, max_len);
      frame_beats = 0;
      if (p == 1 || p == 4) begin
        hold_off_req = 1'b1;
      end

      while (frame_beats < PhaseBeats) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          with_addr = 1'($urandom_range(0, 1));
          cmd = byte_t'($urandom_range(0, 255));
          if (!with_addr) begin
            cmd[7] = 1'b0;  // keep it from being taken as an address
          end
          pick = $urandom_range(0, 39);
          if (pick == 0) begin
            len = byte_t'($urandom_range(0, 255));
          end else if (pick < 5 && cfg_max_len < 8'hFF) begin
            len = byte_t'($urandom_range(int'(cfg_max_len) + 1, 255));
          end else begin
            len = byte_t'($urandom_range(0, (cfg_max_len < 8'd8) ? int'(cfg_max_len) : 8));
          end
          send_frame(with_addr, AddrW'($urandom_range(0, 127)), cmd, len,
                     $urandom_range(0, 99) < 85);
        end else if (pick < 85) begin
          // line noise between frames
          repeat ($urandom_range(1, 4)) send_raw(pick_data(), 1'b0);
        end else begin
          // frame start followed by scrambled, possibly truncated content
          send_raw(cfg_fe);
          repeat ($urandom_range(1, 6)) send_raw(pick_data());
        end
      end
      wait_for_quiet();
    end

    if (sb.mismatches == 0) begin
      $display("** wake_frame_receiver: PASSED **");
    end else begin
      $display("** wake_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/wfr_pkg.sv
rtl/wake_frame_receiver.sv
verif/wake_frame_receiver_tb.sv
